@@ rtl/hptc_pkg.sv @@
package hptc_pkg;

	// Fixed point and field widths
	localparam int FRAC_BITS = 8;
	localparam int RAW_W     = 16;
	localparam int DIFF_W    = RAW_W + 1;
	localparam int MAG_W     = RAW_W;
	localparam int HUM_W     = 7;
	localparam int DH_W      = HUM_W + 1;
	localparam int PROD_W    = MAG_W + HUM_W;
	localparam int DVD_W     = PROD_W + FRAC_BITS;
	localparam int DVS_W     = MAG_W;
	localparam int OUT_W     = 24;
	localparam int Y_W       = DVD_W + 3;
	localparam int TOP_Q8    = 100 << FRAC_BITS;

	// Accept to strobe: two front stages, one cell per quotient bit, one output stage
	localparam int LATENCY   = DVD_W + 3;

	// Configuration port
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_HUM_DBL  = 8'd0,
		REG_SECOND_HUM_DBL = 8'd1,
		REG_FIRST_COUNT    = 8'd2,
		REG_SECOND_COUNT   = 8'd3
	} cfg_reg_t;

	// Word handed from cell to cell along the divider chain
	typedef struct packed {
		logic             vld;
		logic             rv;
		logic             neg;
		logic             zero;
		logic [HUM_W-1:0] h0;
		logic [DVD_W-1:0] dvd;
		logic [DVS_W-1:0] rem;
		logic [DVS_W-1:0] dvs;
	} div_word_t;

endpackage

@@ rtl/humidity_two_point_calibration_top.sv @@
// Two-point humidity calibration.
// Input: a word (raw_humidity, reading_valid) is taken at each rising edge with start
// high and busy low. busy is always low, so a new word may be given every cycle.
// Output: each word gives exactly one result word, shown on humidity_percent_q8,
// result_valid and clamped for one cycle while done is high. Results leave in the
// order the words came in. The receiver cannot stall; none is needed.
// Throughput: one word per cycle. The latency is set by the divider chain, one
// cell per quotient bit (31 cells), plus two front stages and one output stage.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Index 0/1 take the doubled humidity bytes, 2/3 the signed counts;
// other indexes are ignored. Write only with no word in flight.
// Reset: arst_n low clears the calibration registers and every in-flight word; no word
// in flight is delivered. There is no clearing pass.
module humidity_two_point_calibration_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [hptc_pkg::RAW_W-1:0]     raw_humidity,
	input  logic                                  reading_valid,
	output logic                                  done,
	output logic signed [hptc_pkg::OUT_W-1:0]     humidity_percent_q8,
	output logic                                  result_valid,
	output logic                                  clamped,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [hptc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [hptc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	logic [7:0]                               first_hum_dbl_q;
	logic [7:0]                               second_hum_dbl_q;
	logic signed [hptc_pkg::RAW_W-1:0]        first_count_q;
	logic signed [hptc_pkg::RAW_W-1:0]        second_count_q;
	logic                                     accept;
	hptc_pkg::div_word_t                      chain [0:hptc_pkg::DVD_W];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// Write the calibration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hum_dbl_q  <= '0;
			second_hum_dbl_q <= '0;
			first_count_q    <= '0;
			second_count_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				hptc_pkg::REG_FIRST_HUM_DBL:  first_hum_dbl_q  <= cfg_data[7:0];
				hptc_pkg::REG_SECOND_HUM_DBL: second_hum_dbl_q <= cfg_data[7:0];
				hptc_pkg::REG_FIRST_COUNT:    first_count_q    <= cfg_data;
				hptc_pkg::REG_SECOND_COUNT:   second_count_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	hptc_prep u_prep (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (accept),
		.raw_humidity   (raw_humidity),
		.reading_valid  (reading_valid),
		.first_hum_dbl  (first_hum_dbl_q),
		.second_hum_dbl (second_hum_dbl_q),
		.first_count    (first_count_q),
		.second_count   (second_count_q),
		.word           (chain[0])
	);

	// One restoring divide cell per quotient bit
	for (genvar i = 0; i < hptc_pkg::DVD_W; i++) begin : g_cell
		hptc_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.prev_word (chain[i]),
			.next_word (chain[i+1])
		);
	end

	hptc_post u_post (
		.clk                 (clk),
		.arst_n              (arst_n),
		.last_word           (chain[hptc_pkg::DVD_W]),
		.done                (done),
		.humidity_percent_q8 (humidity_percent_q8),
		.result_valid        (result_valid),
		.clamped             (clamped)
	);

	// Every accepted word comes out exactly after the pipeline latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n, hptc_pkg::LATENCY) |->
			(done == $past(accept, hptc_pkg::LATENCY)))
		else $error("result strobe does not match accepted word");

	// An invalid reading gives a zero value and no clamp
	a_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result_valid) |-> (humidity_percent_q8 == '0 && !clamped))
		else $error("invalid reading produced a nonzero result");

	// A valid result never exceeds full scale
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result_valid) |->
			(humidity_percent_q8 <= $signed(hptc_pkg::OUT_W'(hptc_pkg::TOP_Q8))))
		else $error("result above full scale");

	// A clamped result sits at one of the two limits
	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clamped) |->
			(humidity_percent_q8 == $signed(hptc_pkg::OUT_W'(hptc_pkg::TOP_Q8))
			|| humidity_percent_q8 == $signed({1'b1, {(hptc_pkg::OUT_W-1){1'b0}}})))
		else $error("clamped result is not at a limit");

endmodule

@@ rtl/hptc_prep.sv @@
module hptc_prep (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  logic signed [hptc_pkg::RAW_W-1:0] raw_humidity,
	input  logic                          reading_valid,
	input  logic [7:0]                    first_hum_dbl,
	input  logic [7:0]                    second_hum_dbl,
	input  logic signed [hptc_pkg::RAW_W-1:0] first_count,
	input  logic signed [hptc_pkg::RAW_W-1:0] second_count,
	output hptc_pkg::div_word_t           word
);

	logic                                vld_s1;
	logic                                rv_s1;
	logic signed [hptc_pkg::DIFF_W-1:0]  diff_s1;
	logic signed [hptc_pkg::DIFF_W-1:0]  den_s1;
	logic signed [hptc_pkg::DH_W-1:0]    dh_s1;
	logic [hptc_pkg::HUM_W-1:0]          h0_s1;

	logic [hptc_pkg::DIFF_W-1:0]         diff_abs;
	logic [hptc_pkg::DIFF_W-1:0]         den_abs;
	logic [hptc_pkg::DH_W-1:0]           dh_abs;
	logic [hptc_pkg::PROD_W-1:0]         prod;
	hptc_pkg::div_word_t                 word_s2;

	// Stage 1: offsets from the first calibration point
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		rv_s1   <= reading_valid;
		diff_s1 <= {raw_humidity[hptc_pkg::RAW_W-1], raw_humidity}
			- {first_count[hptc_pkg::RAW_W-1], first_count};
		den_s1  <= {second_count[hptc_pkg::RAW_W-1], second_count}
			- {first_count[hptc_pkg::RAW_W-1], first_count};
		dh_s1   <= $signed({1'b0, second_hum_dbl[7:1]}) - $signed({1'b0, first_hum_dbl[7:1]});
		h0_s1   <= first_hum_dbl[7:1];
	end

	// Stage 2: split into sign and magnitude, form the scaled dividend
	always_comb begin
		diff_abs = diff_s1[hptc_pkg::DIFF_W-1] ? hptc_pkg::DIFF_W'(-diff_s1)
			: hptc_pkg::DIFF_W'(diff_s1);
		den_abs  = den_s1[hptc_pkg::DIFF_W-1] ? hptc_pkg::DIFF_W'(-den_s1)
			: hptc_pkg::DIFF_W'(den_s1);
		dh_abs   = dh_s1[hptc_pkg::DH_W-1] ? hptc_pkg::DH_W'(-dh_s1)
			: hptc_pkg::DH_W'(dh_s1);
		prod     = hptc_pkg::PROD_W'(diff_abs[hptc_pkg::MAG_W-1:0])
			* hptc_pkg::PROD_W'(dh_abs[hptc_pkg::HUM_W-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_s2 <= '0;
		end else begin
			word_s2.vld  <= vld_s1;
			word_s2.rv   <= rv_s1;
			word_s2.neg  <= diff_s1[hptc_pkg::DIFF_W-1] ^ dh_s1[hptc_pkg::DH_W-1]
				^ den_s1[hptc_pkg::DIFF_W-1];
			word_s2.zero <= (den_s1 == '0);
			word_s2.h0   <= h0_s1;
			word_s2.dvd  <= {prod, {hptc_pkg::FRAC_BITS{1'b0}}};
			word_s2.rem  <= '0;
			word_s2.dvs  <= den_abs[hptc_pkg::DVS_W-1:0];
		end
	end

	assign word = word_s2;

endmodule

@@ rtl/hptc_div_cell.sv @@
module hptc_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  hptc_pkg::div_word_t prev_word,
	output hptc_pkg::div_word_t next_word
);

	logic [hptc_pkg::DVS_W:0]   part;
	logic [hptc_pkg::DVS_W+1:0] trial;
	logic                       qbit;
	hptc_pkg::div_word_t        word_q;

	// Shift in the next dividend bit and try one subtraction of the divisor
	always_comb begin
		part  = {prev_word.rem, prev_word.dvd[hptc_pkg::DVD_W-1]};
		trial = {1'b0, part} - {2'b00, prev_word.dvs};
		qbit  = ~trial[hptc_pkg::DVS_W+1];
	end

	// Advance the word: keep the remainder, collect the quotient bit at the bottom
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
		end else begin
			word_q.vld  <= prev_word.vld;
			word_q.rv   <= prev_word.rv;
			word_q.neg  <= prev_word.neg;
			word_q.zero <= prev_word.zero;
			word_q.h0   <= prev_word.h0;
			word_q.dvs  <= prev_word.dvs;
			word_q.dvd  <= {prev_word.dvd[hptc_pkg::DVD_W-2:0], qbit};
			word_q.rem  <= qbit ? trial[hptc_pkg::DVS_W-1:0] : part[hptc_pkg::DVS_W-1:0];
		end
	end

	assign next_word = word_q;

endmodule

@@ rtl/hptc_post.sv @@
module hptc_post (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hptc_pkg::div_word_t               last_word,
	output logic                              done,
	output logic signed [hptc_pkg::OUT_W-1:0] humidity_percent_q8,
	output logic                              result_valid,
	output logic                              clamped
);

	localparam logic signed [hptc_pkg::Y_W-1:0] YTop = hptc_pkg::Y_W'(hptc_pkg::TOP_Q8);

	logic [hptc_pkg::Y_W-1:0]          quot;
	logic [hptc_pkg::Y_W-1:0]          base;
	logic signed [hptc_pkg::Y_W-1:0]   y;
	logic                              over;
	logic                              under;
	logic signed [hptc_pkg::OUT_W-1:0] val;
	logic                              clip;

	// Apply the sign to the quotient, add the first point, then limit; an invalid reading gives zero
	always_comb begin
		quot  = last_word.zero ? '0 : hptc_pkg::Y_W'(last_word.dvd);
		base  = hptc_pkg::Y_W'({last_word.h0, {hptc_pkg::FRAC_BITS{1'b0}}});
		y     = last_word.neg ? $signed(base - quot) : $signed(base + quot);
		over  = (y >= YTop);
		under = y[hptc_pkg::Y_W-1] && !(&y[hptc_pkg::Y_W-1:hptc_pkg::OUT_W-1]);
		val   = y[hptc_pkg::OUT_W-1:0];
		clip  = 1'b0;
		if (!last_word.rv) begin
			val = '0;
		end else if (over) begin
			val  = hptc_pkg::OUT_W'(hptc_pkg::TOP_Q8);
			clip = 1'b1;
		end else if (under) begin
			val  = {1'b1, {(hptc_pkg::OUT_W-1){1'b0}}};
			clip = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= last_word.vld;
		end
	end

	// Hold the result word for its one strobe cycle
	always_ff @(posedge clk) begin
		humidity_percent_q8 <= val;
		result_valid        <= last_word.rv;
		clamped             <= clip;
	end

endmodule
